// ===== hw/rtl/at_line_unsolicited_classifier_unit_defines.svh =====
// Assertion macros for the classifier RTL.
// Depends on nothing; files that use these macros provide i_clk and i_rst_n.
`ifndef AT_LINE_UNSOLICITED_CLASSIFIER_UNIT_DEFINES_SVH
`define AT_LINE_UNSOLICITED_CLASSIFIER_UNIT_DEFINES_SVH

// Concurrent check on the rising clock edge, switched off while reset is held.
`define ATLUC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define ATLUC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/atluc_pkg.sv =====
// Package for the unsolicited-line classifier: pattern tables, types and
// byte lookup functions. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package atluc_pkg;

    localparam int unsigned MAX_PATTERN_CHARS_DEF = 32;
    localparam int unsigned PAT_COUNT = 25;
    localparam int unsigned PAT_SLOT  = 28;
    localparam logic [3:0]  SFX_CEIL  = 4'd15;

    // Pattern text, right-justified in the slot (first character is the
    // most significant non-zero byte).
    localparam logic [PAT_SLOT*8-1:0] PAT_TEXT [PAT_COUNT] = '{
        "ready", "busy p", "WIFI ", "+ETH_", "+IPD", "+LINK\137CONN",
        "+STA\137CONNECTED:", "+STA\137DISCONNECTED:", "+DIST\137STA_IP:",
        "+TIME\137UPDATED", "+SCRD:", "Smart get wifi info", "smartconfig type:",
        "smartconfig connected wifi", "Recv ", "Have ", "+QUITT",
        "Will force to restart!!!", "+MQTTCONNECTED", "+MQTTDISCONNECTED",
        "+MQTTSUBRECV", "+MQTTPUB:FAIL", "+MQTTPUB:OK", "CONNECT", "CLOSED"
    };

    localparam logic [4:0] PAT_LEN [PAT_COUNT] = '{
        5'd5, 5'd6, 5'd5, 5'd5, 5'd4, 5'd10,
        5'd15, 5'd18, 5'd13,
        5'd13, 5'd6, 5'd19, 5'd17,
        5'd26, 5'd5, 5'd5, 5'd6,
        5'd24, 5'd14, 5'd17,
        5'd12, 5'd13, 5'd11, 5'd7, 5'd6
    };

    localparam logic PAT_PREFIX [PAT_COUNT] = '{
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0
    };

    localparam logic [63:0] SFX_TEXT [2] = '{"CONNECT", "CLOSED"};
    localparam logic [3:0]  SFX_LEN  [2] = '{4'd7, 4'd6};

    // Digits-comma tracker.
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_SUFFIX = 2'd2,
        PH_FAILED = 2'd3
    } t_idx_phase;

    // Line state apart from the position counter, whose width is a parameter.
    typedef struct packed {
        logic [PAT_COUNT-1:0] alive;
        t_idx_phase           phase;
        logic [3:0]           spos;
        logic [1:0]           salive;
    } t_match_state;

    localparam t_match_state MATCH_CLEAR = '{
        alive:  {PAT_COUNT{1'b1}},
        phase:  PH_FIRST,
        spos:   4'd0,
        salive: 2'b11
    };

    // Character i of pattern p; zero past the end of the text.
    function automatic logic [7:0] pat_byte(input int unsigned p, input logic [4:0] i);
        logic [PAT_SLOT*8-1:0] t;
        int                    base;
        t    = PAT_TEXT[p];
        base = 8 * (int'(PAT_LEN[p]) - 1 - int'(i));
        if (i < PAT_LEN[p]) begin
            return t[base +: 8];
        end
        return 8'd0;
    endfunction

    // Character i of suffix k; zero past the end of the text.
    function automatic logic [7:0] sfx_byte(input int unsigned k, input logic [3:0] i);
        logic [63:0] t;
        int          base;
        t    = SFX_TEXT[k];
        base = 8 * (int'(SFX_LEN[k]) - 1 - int'(i));
        if (i < SFX_LEN[k]) begin
            return t[base +: 8];
        end
        return 8'd0;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/at_line_unsolicited_classifier_unit.sv =====
// Top level of the unsolicited-line classifier for modem response lines.
// Depends on atluc_pkg, atluc_match and the assertion macro header.
//
// Feed the characters of one response line, one transaction each, and mark the
// last with i_line_end; one result transaction follows each line end and says
// whether the line is an unsolicited message (a fixed pattern, a prefix
// pattern, or digits, a comma and then exactly CONNECT or CLOSED). A
// transaction with i_has_char low carries no character; with i_line_end high
// it closes the line on the characters already taken, and a line with no
// characters reports 0. The per-pattern comparators and the verdict sit between
// the line-state registers and the result register, so a new character is taken
// in every cycle unless the input is stalled, and the result of a line end
// appears in the cycle after it is taken. The single result register stalls
// the input only while it holds an untaken result and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module at_line_unsolicited_classifier_unit #(
    parameter int unsigned MAX_PATTERN_CHARS = atluc_pkg::MAX_PATTERN_CHARS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_has_char,
    input  wire logic       i_line_end,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_is_unsolicited
);
    import atluc_pkg::*;

`include "at_line_unsolicited_classifier_unit_defines.svh"

    // The position counter saturates at MAX_PATTERN_CHARS.
    localparam int unsigned POS_W = $clog2(MAX_PATTERN_CHARS + 1);

    logic [POS_W-1:0] r_pos;
    t_match_state     r_state;
    logic             r_out_valid;
    logic             r_out_data;

    logic [POS_W-1:0] n_pos;
    t_match_state     n_state;
    logic             n_verdict;
    logic             in_acc;

    // An input transaction is held back only when the result register is
    // full and its contents cannot leave this cycle.
    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    atluc_match #(
        .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS),
        .POS_W             (POS_W)
    ) u_match (
        .i_char_code (i_char_code),
        .i_has_char  (i_has_char),
        .i_pos       (r_pos),
        .i_state     (r_state),
        .o_pos       (n_pos),
        .o_state     (n_state),
        .o_verdict   (n_verdict)
    );

    // Line state: a line end returns everything to its cleared value, any
    // other accepted transaction advances it by the character it carries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_state <= MATCH_CLEAR;
        end else if (in_acc) begin
            if (i_line_end) begin
                r_pos   <= '0;
                r_state <= MATCH_CLEAR;
            end else begin
                r_pos   <= n_pos;
                r_state <= n_state;
            end
        end
    end

    // Result register. It refills in the same cycle that its old result is
    // taken, so back-to-back line ends flow without a bubble.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_line_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_line_end) begin
            r_out_data <= n_verdict;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_is_unsolicited = r_out_data;

    `ATLUC_ASSERT(a_line_end_gives_result, in_acc && i_line_end |=> r_out_valid,
        "line end without result")
    `ATLUC_ASSERT(a_line_end_clears,
        in_acc && i_line_end |=> r_pos == '0 && r_state == MATCH_CLEAR,
        "line state not cleared after line end")
    `ATLUC_ASSERT(a_suffix_idle,
        r_state.phase != PH_SUFFIX |-> r_state.spos == 4'd0 && r_state.salive == 2'b11,
        "suffix tracker moved outside suffix phase")
    `ATLUC_ASSERT_ALWAYS(a_reset_empties_result, !i_rst_n |=> !r_out_valid,
        "result valid right after reset")

endmodule

`default_nettype wire

// ===== hw/rtl/atluc_match.sv =====
// Next-state and verdict logic for one character of a line.
// Depends on atluc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atluc_match #(
    parameter int unsigned MAX_PATTERN_CHARS = atluc_pkg::MAX_PATTERN_CHARS_DEF,
    parameter int unsigned POS_W             = $clog2(MAX_PATTERN_CHARS + 1)
) (
    input  wire logic [7:0]             i_char_code,
    input  wire logic                   i_has_char,
    input  wire logic [POS_W-1:0]       i_pos,
    input  wire atluc_pkg::t_match_state i_state,
    output logic [POS_W-1:0]            o_pos,
    output atluc_pkg::t_match_state     o_state,
    output logic                        o_verdict
);
    import atluc_pkg::*;

    logic [POS_W-1:0] pos_n;
    t_match_state     st_n;
    logic             digit;
    logic             hit;

    assign digit = (i_char_code >= "0") && (i_char_code <= "9");

    always_comb begin
        pos_n = i_pos;
        st_n  = i_state;
        if (i_has_char) begin
            for (int p = 0; p < PAT_COUNT; p++) begin
                if (i_pos < POS_W'(PAT_LEN[p])) begin
                    if (pat_byte(p, i_pos[4:0]) != i_char_code) begin
                        st_n.alive[p] = 1'b0;
                    end
                end else if (!PAT_PREFIX[p]) begin
                    st_n.alive[p] = 1'b0;
                end
            end
            if (i_pos != POS_W'(MAX_PATTERN_CHARS)) begin
                pos_n = i_pos + 1'b1;
            end

            case (i_state.phase)
                PH_FIRST: begin
                    st_n.phase = digit ? PH_DIGITS : PH_FAILED;
                end
                PH_DIGITS: begin
                    if (!digit) begin
                        st_n.phase = (i_char_code == ",") ? PH_SUFFIX : PH_FAILED;
                    end
                end
                PH_SUFFIX: begin
                    for (int k = 0; k < 2; k++) begin
                        if (i_state.spos >= SFX_LEN[k] ||
                            sfx_byte(k, i_state.spos) != i_char_code) begin
                            st_n.salive[k] = 1'b0;
                        end
                    end
                    if (i_state.spos != SFX_CEIL) begin
                        st_n.spos = i_state.spos + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The verdict looks at the state as it stands after this character.
    always_comb begin
        hit = 1'b0;
        for (int p = 0; p < PAT_COUNT; p++) begin
            if (st_n.alive[p]) begin
                if (PAT_PREFIX[p] ? (pos_n >= POS_W'(PAT_LEN[p]))
                                  : (pos_n == POS_W'(PAT_LEN[p]))) begin
                    hit = 1'b1;
                end
            end
        end
        if (st_n.phase == PH_SUFFIX) begin
            for (int k = 0; k < 2; k++) begin
                if (st_n.salive[k] && st_n.spos == SFX_LEN[k]) begin
                    hit = 1'b1;
                end
            end
        end
    end

    assign o_pos     = pos_n;
    assign o_state   = st_n;
    assign o_verdict = hit;

endmodule

`default_nettype wire

// ===== sim/at_line_unsolicited_classifier_unit_tb.sv =====
// Self-checking testbench for the unsolicited-line classifier: feeds response lines one
// character per transaction and checks every line verdict against a line matcher kept here.
// Depends on atluc_pkg (digits-comma phase enum) and the at_line_unsolicited_classifier_unit RTL.
`timescale 1ns / 1ps

module at_line_unsolicited_classifier_unit_tb;

    // ------------------------------------------------------------------
    // Run constants.
    // ------------------------------------------------------------------
    localparam int          PAT_NUM      = 25;
    localparam logic [5:0]  POS_CEIL     = 6'd32;   // line position counter saturates here
    localparam logic [3:0]  TAIL_CEIL    = 4'd15;   // position after the comma saturates here
    localparam int          RANDOM_XACTS = 620;
    localparam int          QUIET_XACTS  = 100;     // last stretch of the run has no idling
    localparam int          DIR_ROWS     = 25;
    localparam int          CYCLE_LIMIT  = 400000;

    // How a directed row's verdict is obtained: typed in, or taken from the matcher.
    typedef enum logic [1:0] {
        WANT_ZERO    = 2'd0,
        WANT_ONE     = 2'd1,
        WANT_PREDICT = 2'd2
    } t_want;

    typedef struct packed {
        logic [7:0] code;
        logic       has;
        logic       last;
        t_want      want;
    } t_dir_row;

    // ------------------------------------------------------------------
    // Directed stimulus. Each row is one input transaction; a row with
    // last set closes the line, and its verdict is typed in where it is
    // obvious from the pattern list.
    // ------------------------------------------------------------------
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // Empty line: no character, line end only.
        '{8'h00, 1'b0, 1'b1, WANT_ZERO},
        // Single-character lines at both byte extremes.
        '{8'h00, 1'b1, 1'b1, WANT_ZERO},
        '{8'hFF, 1'b1, 1'b1, WANT_ZERO},
        // Exact pattern, ended on its last character.
        '{"r", 1'b1, 1'b0, WANT_PREDICT},
        '{"e", 1'b1, 1'b0, WANT_PREDICT},
        '{"a", 1'b1, 1'b0, WANT_PREDICT},
        '{"d", 1'b1, 1'b0, WANT_PREDICT},
        '{"y", 1'b1, 1'b1, WANT_ONE},
        // Prefix pattern with an empty filler transaction in the middle, closed
        // by a line end that carries no character.
        '{"+", 1'b1, 1'b0, WANT_PREDICT},
        '{"I", 1'b1, 1'b0, WANT_PREDICT},
        '{8'hA5, 1'b0, 1'b0, WANT_PREDICT},
        '{"P", 1'b1, 1'b0, WANT_PREDICT},
        '{"D", 1'b1, 1'b0, WANT_PREDICT},
        '{8'h3C, 1'b0, 1'b1, WANT_ONE},
        // Digits, comma, then exactly CLOSED.
        '{"7", 1'b1, 1'b0, WANT_PREDICT},
        '{",", 1'b1, 1'b0, WANT_PREDICT},
        '{"C", 1'b1, 1'b0, WANT_PREDICT},
        '{"L", 1'b1, 1'b0, WANT_PREDICT},
        '{"O", 1'b1, 1'b0, WANT_PREDICT},
        '{"S", 1'b1, 1'b0, WANT_PREDICT},
        '{"E", 1'b1, 1'b0, WANT_PREDICT},
        '{"D", 1'b1, 1'b1, WANT_ONE},
        // Digits and comma with nothing after them do not match.
        '{"0", 1'b1, 1'b0, WANT_PREDICT},
        '{",", 1'b1, 1'b0, WANT_PREDICT},
        '{8'hFF, 1'b0, 1'b1, WANT_ZERO}
    };

    // Pattern list of the matcher. Open-ended entries match any line that starts
    // with their text; the others must equal the whole line.
    string pat_list [PAT_NUM] = '{
        "ready", "busy p", "WIFI ", "+ETH_", "+IPD", "+LINK\137CONN",
        "+STA\137CONNECTED:", "+STA\137DISCONNECTED:", "+DIST\137STA_IP:",
        "+TIME\137UPDATED", "+SCRD:", "Smart get wifi info", "smartconfig type:",
        "smartconfig connected wifi", "Recv ", "Have ", "+QUITT",
        "Will force to restart!!!", "+MQTTCONNECTED", "+MQTTDISCONNECTED",
        "+MQTTSUBRECV", "+MQTTPUB:FAIL", "+MQTTPUB:OK", "CONNECT", "CLOSED"
    };
    bit pat_open_end [PAT_NUM] = '{
        0, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 0, 1, 0, 1, 1, 0, 0, 1, 1, 1, 0, 0, 0, 0
    };
    // Words allowed after "<digits>,".
    string tail_list [2] = '{"CONNECT", "CLOSED"};

    // ------------------------------------------------------------------
    // DUT ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic [7:0] i_char_code      = 8'h00;
    logic       i_has_char       = 1'b0;
    logic       i_line_end       = 1'b0;
    logic       i_stall          = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_is_unsolicited;

    at_line_unsolicited_classifier_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_code      (i_char_code),
        .i_has_char       (i_has_char),
        .i_line_end       (i_line_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_is_unsolicited (o_is_unsolicited)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Line matcher state: a private copy of what the block keeps per line.
    // ------------------------------------------------------------------
    logic [5:0]             line_pos;
    logic [PAT_NUM-1:0]     pat_live;
    atluc_pkg::t_idx_phase  digit_phase;
    logic [3:0]             tail_pos;
    logic [1:0]             tail_live;

    // Verdicts of lines that were accepted but whose result has not come back yet.
    logic                   verdict_q [$];

    // Bookkeeping.
    int         err_count     = 0;
    int         xacts_used    = 0;   // transactions that carry a character or end a line
    int         lines_checked = 0;
    int         ones_seen     = 0;
    int         cycle_count   = 0;
    int         tx_idle_pct   = 0;
    int         rx_idle_pct   = 0;
    int         rx_left       = 0;
    bit         quiet         = 1'b0;
    logic [7:0] line_bytes [$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Start of a new line: every pattern and both words after the comma are possible again.
    function automatic void unsol_clear();
        line_pos    = '0;
        pat_live    = '1;
        digit_phase = atluc_pkg::PH_FIRST;
        tail_pos    = '0;
        tail_live   = 2'b11;
    endfunction

    // Advance the matcher by one character of the line.
    function automatic void unsol_take_char(input logic [7:0] c);
        string s;
        int    n;
        logic  keep;
        logic  is_digit;
        for (int p = 0; p < PAT_NUM; p++) begin
            s = pat_list[p];
            n = s.len();
            // Inside the text the byte must agree; past it only open-ended patterns live on.
            if (int'(line_pos) < n) begin
                keep = (8'(s[line_pos]) == c);
            end else begin
                keep = pat_open_end[p];
            end
            if (!keep) begin
                pat_live[p] = 1'b0;
            end
        end
        if (line_pos < POS_CEIL) begin
            line_pos = line_pos + 6'd1;
        end

        is_digit = (c >= "0") && (c <= "9");
        case (digit_phase)
            atluc_pkg::PH_FIRST: begin
                digit_phase = is_digit ? atluc_pkg::PH_DIGITS : atluc_pkg::PH_FAILED;
            end
            atluc_pkg::PH_DIGITS: begin
                if (!is_digit) begin
                    digit_phase = (c == ",") ? atluc_pkg::PH_SUFFIX : atluc_pkg::PH_FAILED;
                end
            end
            atluc_pkg::PH_SUFFIX: begin
                for (int k = 0; k < 2; k++) begin
                    s = tail_list[k];
                    if (int'(tail_pos) >= s.len() || 8'(s[tail_pos]) != c) begin
                        tail_live[k] = 1'b0;
                    end
                end
                if (tail_pos < TAIL_CEIL) begin
                    tail_pos = tail_pos + 4'd1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Verdict for the line taken so far.
    function automatic logic unsol_verdict();
        string s;
        int    n;
        for (int p = 0; p < PAT_NUM; p++) begin
            s = pat_list[p];
            n = s.len();
            if (pat_live[p]) begin
                if (pat_open_end[p] ? (int'(line_pos) >= n) : (int'(line_pos) == n)) begin
                    return 1'b1;
                end
            end
        end
        if (digit_phase == atluc_pkg::PH_SUFFIX) begin
            for (int k = 0; k < 2; k++) begin
                s = tail_list[k];
                if (tail_live[k] && int'(tail_pos) == s.len()) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Sender. A transaction is presented at a rising edge and held until an
    // edge sees it with o_stall low; only then does the matcher advance.
    // Idle bursts are inserted before a transaction, so the next valid is
    // always raised at a later edge than the one that lowered it.
    // ------------------------------------------------------------------
    task automatic send_xact(input logic [7:0] code, input logic has, input logic last,
                             input t_want want);
        logic v;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= code;
        i_has_char  <= has;
        i_line_end  <= last;
        do @(posedge i_clk); while (o_stall);

        if (has || last) begin
            xacts_used++;
        end
        if (has) begin
            unsol_take_char(code);
        end
        if (last) begin
            v = unsol_verdict();
            unsol_clear();
            case (want)
                WANT_ZERO: v = 1'b0;
                WANT_ONE:  v = 1'b1;
                default:   begin
                end
            endcase
            verdict_q.push_back(v);
        end
    endtask

    // Sender holds off until every outstanding line has been answered.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
    endtask

    // Damage a line slightly: drop the last byte, overwrite one, or add one.
    task automatic mangle_line();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0 && line_bytes.size() != 0) begin
            void'(line_bytes.pop_back());
        end else if (pick == 1 && line_bytes.size() != 0) begin
            line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom_range(255));
        end else begin
            line_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // Build one random line. Most lines are patterns or "<digits>,WORD" lines so that
    // the matcher gets deep into its tables; the rest are near misses, raw bytes and
    // over-long lines that can saturate the position counters.
    task automatic make_random_line();
        int    kind;
        int    p;
        int    n;
        string s;
        line_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 35) begin
            p = $urandom_range(PAT_NUM - 1);
            s = pat_list[p];
            for (int i = 0; i < s.len(); i++) begin
                line_bytes.push_back(8'(s[i]));
            end
            if (pat_open_end[p] && $urandom_range(1) == 1) begin
                repeat ($urandom_range(5, 1)) line_bytes.push_back(8'($urandom_range(126, 32)));
            end
            if ($urandom_range(9) < 3) begin
                mangle_line();
            end
        end else if (kind < 60) begin
            repeat ($urandom_range(3, 1)) line_bytes.push_back(8'("0" + $urandom_range(9)));
            line_bytes.push_back(8'(","));
            s = tail_list[$urandom_range(1)];
            for (int i = 0; i < s.len(); i++) begin
                line_bytes.push_back(8'(s[i]));
            end
            if ($urandom_range(9) < 3) begin
                mangle_line();
            end
        end else if (kind < 72) begin
            repeat ($urandom_range(6)) line_bytes.push_back(8'($urandom_range(255)));
        end else if (kind < 82) begin
            // Long line, of 28 to 45 bytes, reaching up to and past the position ceiling.
            case ($urandom_range(2))
                0: begin
                    do p = $urandom_range(PAT_NUM - 1); while (!pat_open_end[p]);
                    s = pat_list[p];
                    for (int i = 0; i < s.len(); i++) begin
                        line_bytes.push_back(8'(s[i]));
                    end
                end
                1: begin
                    line_bytes.push_back(8'("1"));
                    line_bytes.push_back(8'("2"));
                    line_bytes.push_back(8'(","));
                end
                default: begin
                end
            endcase
            n = $urandom_range(45, 28);
            while (line_bytes.size() < n) begin
                line_bytes.push_back(8'($urandom_range(255)));
            end
        end else begin
            // A pattern cut short, possibly down to nothing.
            p = $urandom_range(PAT_NUM - 1);
            s = pat_list[p];
            n = $urandom_range(s.len());
            for (int i = 0; i < n; i++) begin
                line_bytes.push_back(8'(s[i]));
            end
        end
    endtask

    // Send the built line. Filler transactions without a character are scattered in,
    // and some lines are closed by a separate end transaction with no character.
    task automatic emit_line();
        logic sep;
        int   n;
        n   = line_bytes.size();
        sep = (n == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                send_xact(8'($urandom_range(255)), 1'b0, 1'b0, WANT_PREDICT);
            end
            send_xact(line_bytes[i], 1'b1, (i == n - 1) && !sep, WANT_PREDICT);
        end
        if (sep) begin
            send_xact(8'($urandom_range(255)), 1'b0, 1'b1, WANT_PREDICT);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker. A result transaction is taken at an edge where
    // o_valid is high and our i_stall is low; it is compared with the oldest
    // waiting verdict. i_stall is then set for the next cycle, in random
    // bursts, with a single assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result %0b with no line waiting", o_is_unsolicited));
            end else begin
                if (o_is_unsolicited !== verdict_q[0]) begin
                    report_mismatch($sformatf("line %0d: is_unsolicited %b, expected %b",
                                              lines_checked, o_is_unsolicited, verdict_q[0]));
                end
                if (verdict_q[0]) begin
                    ones_seen++;
                end
                void'(verdict_q.pop_front());
                lines_checked++;
            end
        end

        if (quiet || !i_rst_n) begin
            rx_left = 0;
        end else if (rx_left > 0) begin
            rx_left = rx_left - 1;
        end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
            rx_left = $urandom_range(14, 1);
        end
        i_stall <= (rx_left > 0);
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int lines_made;
        lines_made = 0;
        unsol_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, with light idling on both sides.
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_xact(DIR_TABLE[r].code, DIR_TABLE[r].has, DIR_TABLE[r].last,
                      DIR_TABLE[r].want);
        end
        hold_until_drained();

        // Random lines. Idling levels change per line, including stretches of none;
        // the final stretch runs at full rate on both sides.
        while (xacts_used < DIR_ROWS + RANDOM_XACTS) begin
            if (xacts_used >= DIR_ROWS + RANDOM_XACTS - QUIET_XACTS) begin
                quiet       = 1'b1;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                case ($urandom_range(3))
                    0:       tx_idle_pct = 0;
                    1:       tx_idle_pct = 8;
                    2:       tx_idle_pct = 25;
                    default: tx_idle_pct = 50;
                endcase
                case ($urandom_range(3))
                    0:       rx_idle_pct = 0;
                    1:       rx_idle_pct = 8;
                    2:       rx_idle_pct = 25;
                    default: rx_idle_pct = 50;
                endcase
            end
            make_random_line();
            emit_line();
            lines_made++;
            // Once, after the fortieth random line, the sender waits for every answer.
            if (lines_made == 40) begin
                hold_until_drained();
            end
        end

        // Drain, then keep the clock running so that any stray result can show.
        i_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
        repeat (6) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            report_mismatch($sformatf("%0d line verdicts never arrived", verdict_q.size()));
        end

        $display("Checked %0d line verdicts (%0d unsolicited) from %0d transactions:",
                 lines_checked, ones_seen, xacts_used);
        $display("  exact, prefix, digits-comma, empty, mangled and saturating long lines.");
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== at_line_unsolicited_classifier_unit.f =====
+incdir+hw/rtl
hw/rtl/atluc_pkg.sv
hw/rtl/atluc_match.sv
hw/rtl/at_line_unsolicited_classifier_unit.sv
sim/at_line_unsolicited_classifier_unit_tb.sv
